[rtl/core/dcs_pkg.sv]
// Shared types and constants for the difference constraint solver.
// No dependencies.
package dcs_pkg;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NEGCYCLE = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   localparam int NodeW  = 7;
   localparam int WeightW = 16;
   localparam int DistW  = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_PASS_START,
      ST_EDGE_RD,
      ST_SRC_RD,
      ST_RELAX,
      ST_PASS_END,
      ST_EMIT_RD,
      ST_EMIT,
      ST_EMIT_ONE
   } state_type;

endpackage

[rtl/core/dcs_if.sv]
// Valid/ready channel interfaces for the solver's request, response and csr ports.
// No dependencies.
interface dcs_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [6:0] src_node;
   logic [6:0] dst_node;
   logic signed [15:0] weight;
   modport source (output valid, cmd, src_node, dst_node, weight, input ready);
   modport sink   (input valid, cmd, src_node, dst_node, weight, output ready);
endinterface

interface dcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  node_index;
   logic signed [31:0] distance;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, node_index, distance, status, last, input ready);
   modport sink   (input valid, node_index, distance, status, last, output ready);
endinterface

interface dcs_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[rtl/core/difference_constraint_solver_unit.sv]
// Difference constraint solver top level: edge loading, relaxation sequencer, results.
// Depends on dcs_pkg, dcs_if, dcs_edge_mem and dcs_node_mem.
//
// Usage: the req channel carries items. A load item (cmd 0) stores the edge
// src_node -> dst_node of the given weight; edges with a node of 0 or above
// MAX_NODES are ignored, and edges past MAX_EDGES set an overflow flag.
// A solve item (cmd 1) runs Bellman-Ford over the stored edges and then gives
// one rsp item per node (node_index, distance, status 0, last on the final one),
// or a single item with status 1 on a negative cycle or status 2 on overflow.
// Load items are accepted back to back while the unit is idle and no result
// is pending. A solve is accepted and then initializes the node table. Each
// pass has a start step, then for each edge an edge read, tail read, head
// read and the compare with write-back, then an end step; there are up to
// node_count + 2 passes. Readout alternates a node read and an emit for each
// node, and waits when the receiver stalls.
// The csr channel writes node_count; it is always ready.
// Reset clears the edge count and overflow flag and sets node_count to MAX_NODES (at most 127).
// When the receiver stalls, the result is held and the sequencer waits.
module difference_constraint_solver_unit #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   dcs_req_if.sink     req,
   dcs_rsp_if.source   rsp,
   dcs_csr_if.sink     csr
);
   localparam int NIdxW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CntW   = $clog2(MAX_NODES + 1);
   localparam int HopW   = CntW + 1;
   localparam int EAddrW = $clog2(MAX_EDGES);
   localparam int ECntW  = $clog2(MAX_EDGES + 1);
   localparam int PassW  = $clog2(MAX_NODES + 3);
   localparam int EdgeW  = 2 * NIdxW + dcs_pkg::WeightW;
   localparam int DistW  = dcs_pkg::DistW;

   dcs_pkg::state_type state_ff, state_in;

   logic [6:0]         node_count_ff;
   logic [ECntW-1:0]   edge_total_ff, edge_total_in;
   logic               overflow_ff, overflow_in;
   logic [ECntW-1:0]   eidx_ff, eidx_in;
   logic [CntW-1:0]    vidx_ff, vidx_in;
   logic [PassW-1:0]   pass_ff, pass_in;
   logic               changed_ff, changed_in;
   logic [EdgeW-1:0]   edge_ff, edge_in;
   logic [DistW+HopW-1:0] src_ff, src_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_idx_ff, rsp_idx_in;
   logic [DistW-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   // Edge memory ports.
   logic               ewr_en;
   logic [EAddrW-1:0]  ewr_addr, erd_addr;
   logic [EdgeW-1:0]   ewr_data, erd_data;

   // Node memory ports.
   logic               nwr_en;
   logic [NIdxW-1:0]   nwr_addr, nrd_addr;
   logic [DistW+HopW-1:0] nwr_data, nrd_data;

   // Effective node count, clamped to 1..MAX_NODES.
   logic [CntW-1:0] n_use;
   always_comb begin
      if (node_count_ff == 7'd0) begin
         n_use = CntW'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_use = CntW'(MAX_NODES);
      end else begin
         n_use = CntW'(node_count_ff);
      end
   end

   // Fields of the edge under relaxation and its candidate distance.
   logic [NIdxW-1:0]   e_src, e_dst;
   logic signed [dcs_pkg::WeightW-1:0] e_wt;
   logic signed [DistW:0] cand;
   logic signed [DistW-1:0] src_dist, dst_dist;
   logic [HopW-1:0]    new_hop;
   logic               e_in_range;
   always_comb begin
      e_src    = edge_ff[EdgeW-1 -: NIdxW];
      e_dst    = edge_ff[dcs_pkg::WeightW +: NIdxW];
      e_wt     = edge_ff[dcs_pkg::WeightW-1:0];
      src_dist = src_ff[DistW+HopW-1 -: DistW];
      dst_dist = nrd_data[DistW+HopW-1 -: DistW];
      cand     = (DistW+1)'(src_dist) + (DistW+1)'(e_wt);
      new_hop  = src_ff[HopW-1:0] + HopW'(1);
      e_in_range = (CntW'(e_src) < n_use) && (CntW'(e_dst) < n_use);
   end

   logic req_fire, req_node_ok, rsp_free;
   assign req.ready = (state_ff == dcs_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req.valid && req.ready;
   assign req_node_ok = (req.src_node != 7'd0) && (req.dst_node != 7'd0) &&
                        (32'(req.src_node) <= MAX_NODES) && (32'(req.dst_node) <= MAX_NODES);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   assign csr.ready = 1'b1;

   // Sequencer: load, init, relaxation passes and result readout.
   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      eidx_in       = eidx_ff;
      vidx_in       = vidx_ff;
      pass_in       = pass_ff;
      changed_in    = changed_ff;
      edge_in       = edge_ff;
      src_in        = src_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ewr_en   = 1'b0;
      ewr_addr = edge_total_ff[EAddrW-1:0];
      ewr_data = {NIdxW'(req.src_node - 7'd1), NIdxW'(req.dst_node - 7'd1), req.weight};
      erd_addr = eidx_ff[EAddrW-1:0];
      nwr_en   = 1'b0;
      nwr_addr = vidx_ff[NIdxW-1:0];
      nwr_data = {DistW'(0), HopW'(1)};
      nrd_addr = vidx_ff[NIdxW-1:0];
      unique case (state_ff)
         dcs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req.cmd == dcs_pkg::CMD_LOAD) begin
                  if (req_node_ok) begin
                     if (32'(edge_total_ff) >= MAX_EDGES) begin
                        overflow_in = 1'b1;
                     end else begin
                        ewr_en = 1'b1;
                        edge_total_in = edge_total_ff + ECntW'(1);
                     end
                  end
               end else if (overflow_ff) begin
                  state_in = dcs_pkg::ST_EMIT_ONE;
                  rsp_status_in = dcs_pkg::STATUS_OVERFLOW;
               end else begin
                  vidx_in  = '0;
                  state_in = dcs_pkg::ST_INIT;
               end
            end
         end
         dcs_pkg::ST_INIT: begin
            nwr_en = 1'b1;
            vidx_in = vidx_ff + CntW'(1);
            if (vidx_ff + CntW'(1) == n_use) begin
               pass_in  = '0;
               state_in = dcs_pkg::ST_PASS_START;
            end
         end
         dcs_pkg::ST_PASS_START: begin
            eidx_in    = '0;
            changed_in = 1'b0;
            state_in   = (edge_total_ff == '0) ? dcs_pkg::ST_PASS_END : dcs_pkg::ST_EDGE_RD;
         end
         dcs_pkg::ST_EDGE_RD: begin
            // Edge data arrives next cycle; latch it and read the tail node.
            state_in = dcs_pkg::ST_SRC_RD;
         end
         dcs_pkg::ST_SRC_RD: begin
            edge_in  = erd_data;
            nrd_addr = erd_data[EdgeW-1 -: NIdxW];
            state_in = dcs_pkg::ST_RELAX;
         end
         dcs_pkg::ST_RELAX: begin
            // Tail data is ready now; read the head next.
            src_in   = nrd_data;
            nrd_addr = e_dst;
            state_in = dcs_pkg::ST_PASS_END;
            eidx_in  = eidx_ff;
         end
         dcs_pkg::ST_PASS_END: begin
            if (eidx_ff != edge_total_ff) begin
               // Compare with head distance and write back.
               if (e_in_range && (cand < (DistW+1)'(dst_dist))) begin
                  nwr_en   = 1'b1;
                  nwr_addr = e_dst;
                  nwr_data = {cand[DistW-1:0], new_hop};
                  changed_in = 1'b1;
               end
               if (e_in_range && (cand < (DistW+1)'(dst_dist)) &&
                   (new_hop > HopW'(n_use))) begin
                  state_in = dcs_pkg::ST_EMIT_ONE;
                  rsp_status_in = dcs_pkg::STATUS_NEGCYCLE;
               end else if (eidx_ff + ECntW'(1) == edge_total_ff) begin
                  eidx_in  = eidx_ff + ECntW'(1);
                  state_in = dcs_pkg::ST_PASS_END;
               end else begin
                  eidx_in  = eidx_ff + ECntW'(1);
                  state_in = dcs_pkg::ST_EDGE_RD;
               end
            end else if (!changed_in) begin
               vidx_in  = '0;
               state_in = dcs_pkg::ST_EMIT_RD;
            end else if (32'(pass_ff) + 1 >= 32'(n_use) + 2) begin
               state_in = dcs_pkg::ST_EMIT_ONE;
               rsp_status_in = dcs_pkg::STATUS_NEGCYCLE;
            end else begin
               pass_in  = pass_ff + PassW'(1);
               state_in = dcs_pkg::ST_PASS_START;
            end
         end
         dcs_pkg::ST_EMIT_RD: begin
            state_in = dcs_pkg::ST_EMIT;
         end
         dcs_pkg::ST_EMIT: begin
            nrd_addr = vidx_ff[NIdxW-1:0];
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = 7'(vidx_ff) + 7'd1;
               rsp_dist_in   = nrd_data[DistW+HopW-1 -: DistW];
               rsp_status_in = dcs_pkg::STATUS_OK;
               rsp_last_in   = (vidx_ff + CntW'(1) == n_use);
               vidx_in = vidx_ff + CntW'(1);
               if (vidx_ff + CntW'(1) == n_use) begin
                  edge_total_in = '0;
                  overflow_in   = 1'b0;
                  state_in      = dcs_pkg::ST_IDLE;
               end else begin
                  state_in = dcs_pkg::ST_EMIT_RD;
               end
            end
         end
         dcs_pkg::ST_EMIT_ONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = 7'd0;
               rsp_dist_in   = '0;
               rsp_last_in   = 1'b1;
               edge_total_in = '0;
               overflow_in   = 1'b0;
               state_in      = dcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcs_pkg::ST_IDLE;
         end
      endcase
      if (state_ff == dcs_pkg::ST_EDGE_RD) begin
         erd_addr = eidx_ff[EAddrW-1:0];
      end
      if (state_ff == dcs_pkg::ST_EMIT_RD) begin
         nrd_addr = vidx_ff[NIdxW-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dcs_pkg::ST_IDLE;
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         node_count_ff <= 7'(MAX_NODES > 127 ? 127 : MAX_NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            node_count_ff <= csr.data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      eidx_ff       <= eidx_in;
      vidx_ff       <= vidx_in;
      pass_ff       <= pass_in;
      changed_ff    <= changed_in;
      edge_ff       <= edge_in;
      src_ff        <= src_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   dcs_edge_mem #(.Depth(MAX_EDGES), .AddrW(EAddrW), .NIdxW(NIdxW)) u_edge_mem (
      .clock   (clock),
      .wr_en   (ewr_en),
      .wr_addr (ewr_addr),
      .wr_data (ewr_data),
      .rd_addr (erd_addr),
      .rd_data (erd_data)
   );

   dcs_node_mem #(.Depth(MAX_NODES), .AddrW(NIdxW), .HopW(HopW)) u_node_mem (
      .clock   (clock),
      .wr_en   (nwr_en),
      .wr_addr (nwr_addr),
      .wr_data (nwr_data),
      .rd_addr (nrd_addr),
      .rd_data (nrd_data)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.node_index = rsp_idx_ff;
   assign rsp.distance   = rsp_dist_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.last       = rsp_last_ff;
endmodule

[rtl/core/dcs_edge_mem.sv]
// Edge store: one synchronous write port, one registered read port.
// Depends on dcs_pkg.
module dcs_edge_mem #(
   parameter int Depth = 1024,
   parameter int AddrW = 10,
   parameter int NIdxW = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AddrW-1:0]             wr_addr,
   input  logic [2*NIdxW+dcs_pkg::WeightW-1:0] wr_data,
   input  logic [AddrW-1:0]             rd_addr,
   output logic [2*NIdxW+dcs_pkg::WeightW-1:0] rd_data
);
   logic [2*NIdxW+dcs_pkg::WeightW-1:0] mem [Depth];

   // Write then registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/dcs_node_mem.sv]
// Node table: distance and hop count per node, one write and one read port.
// Depends on dcs_pkg.
module dcs_node_mem #(
   parameter int Depth = 64,
   parameter int AddrW = 6,
   parameter int HopW = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrW-1:0]              wr_addr,
   input  logic [dcs_pkg::DistW+HopW-1:0] wr_data,
   input  logic [AddrW-1:0]              rd_addr,
   output logic [dcs_pkg::DistW+HopW-1:0] rd_data
);
   logic [dcs_pkg::DistW+HopW-1:0] mem [Depth];

   // Registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/dcs_checker.sv]
// Port-level checks for the solver, bound to the top level.
// Depends on dcs_pkg.
module dcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_node_index,
   input logic [31:0] rsp_distance,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);
   // A held result stays valid with its distance and status unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) && $stable(rsp_status))
      else $error("stalled result changed");

   // Error results are final, with node index 0.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dcs_pkg::STATUS_OK) |-> rsp_last && (rsp_node_index == 7'd0))
      else $error("error result not final");

   // Feasible distances are never positive.
   a_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dcs_pkg::STATUS_OK) |->
         !(rsp_distance != 32'd0 && !rsp_distance[31]))
      else $error("positive distance");

   // Status code in range.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= dcs_pkg::STATUS_OVERFLOW)
      else $error("bad status");
endmodule

bind difference_constraint_solver_unit dcs_checker u_dcs_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_node_index (rsp.node_index),
   .rsp_distance   (rsp.distance),
   .rsp_status     (rsp.status),
   .rsp_last       (rsp.last)
);
